// File: rtl/core/dtsc_pkg.sv
// dtsc_pkg: types, codes and reset constants of the debounced trigger shot counter.
// No dependencies; every other file of the block refers to it, the RTL by scoped names and the testbench by import.
`timescale 1ns / 1ps

package dtsc_pkg;

    localparam int DEB_W   = 16;
    localparam int HOLD_W  = 20;
    localparam int SHOTS_W = 8;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 20;

    localparam logic [DEB_W-1:0]   DEBOUNCE_LENGTH_RST    = DEB_W'(5000);
    localparam logic [HOLD_W-1:0]  RELOAD_HOLD_LENGTH_RST = HOLD_W'(300000);
    localparam logic [SHOTS_W-1:0] RELOAD_SHOTS_RST       = SHOTS_W'(10);
    localparam logic [SHOTS_W-1:0] INITIAL_SHOTS_RST      = SHOTS_W'(10);
    localparam logic               TRIGGER_ENABLED_RST    = 1'b1;
    localparam logic               IGNORE_GUN_PIN_RST     = 1'b0;
    localparam logic [HOLD_W-1:0]  HOLD_MAX               = {HOLD_W{1'b1}};

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_DEBOUNCE_LENGTH    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_RELOAD_HOLD_LENGTH = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RELOAD_SHOTS       = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_INITIAL_SHOTS      = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_TRIGGER_ENABLED    = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_IGNORE_GUN_PIN     = 3'd5;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Sound event codes
    localparam logic [1:0] SND_NONE   = 2'd0;
    localparam logic [1:0] SND_FIRE   = 2'd1;
    localparam logic [1:0] SND_EMPTY  = 2'd2;
    localparam logic [1:0] SND_RELOAD = 2'd3;

    // Reported phase codes
    localparam logic [1:0] PHC_IDLE        = 2'd0;
    localparam logic [1:0] PHC_DEB_PRESS   = 2'd1;
    localparam logic [1:0] PHC_PRESSED     = 2'd2;
    localparam logic [1:0] PHC_DEB_RELEASE = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'b0001,
        PH_DEB_PRESS   = 4'b0010,
        PH_PRESSED     = 4'b0100,
        PH_DEB_RELEASE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [DEB_W-1:0]   debounce_length;
        logic [HOLD_W-1:0]  reload_hold_length;
        logic [SHOTS_W-1:0] reload_shots;
        logic               trigger_enabled;
        logic               ignore_gun_pin;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic               gun_level;
        logic               button_level;
        logic               reload_timer_busy;
        logic [SHOTS_W-1:0] new_shot_count;
    } t_item;

    typedef struct packed {
        logic               fire_pulse;
        logic [1:0]         sound_event;
        logic               start_reload_timer;
        logic [SHOTS_W-1:0] shots_remaining;
        logic [1:0]         phase_now;
    } t_result;

endpackage

// File: rtl/core/dtsc_if.sv
// dtsc interfaces: valid/ready channels for input items, results and config writes.
// Depends on dtsc_pkg for field widths.
`timescale 1ns / 1ps

interface dtsc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic                         gun_level;
    logic                         button_level;
    logic                         reload_timer_busy;
    logic [dtsc_pkg::SHOTS_W-1:0] new_shot_count;

    modport source (output valid, kind, gun_level, button_level, reload_timer_busy,
                    new_shot_count, input ready);
    modport sink   (input valid, kind, gun_level, button_level, reload_timer_busy,
                    new_shot_count, output ready);
endinterface

interface dtsc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         fire_pulse;
    logic [1:0]                   sound_event;
    logic                         start_reload_timer;
    logic [dtsc_pkg::SHOTS_W-1:0] shots_remaining;
    logic [1:0]                   phase_now;

    modport source (output valid, fire_pulse, sound_event, start_reload_timer,
                    shots_remaining, phase_now, input ready);
    modport sink   (input valid, fire_pulse, sound_event, start_reload_timer,
                    shots_remaining, phase_now, output ready);
endinterface

interface dtsc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dtsc_pkg::CIDX_W-1:0]  index;
    logic [dtsc_pkg::CDATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/dtsc_cfg_regs.sv
// dtsc_cfg_regs: configuration register file, written one register per transaction.
// Depends on dtsc_pkg.
`timescale 1ns / 1ps

module dtsc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [dtsc_pkg::CIDX_W-1:0]  i_index,
    input  logic [dtsc_pkg::CDATA_W-1:0] i_data,
    output dtsc_pkg::t_cfg               o_cfg
);

    dtsc_pkg::t_cfg r_cfg;

    // The initial shot count only sets the count after reset, and reset restores
    // its default, so a write to it has no visible effect: accept and drop it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_length    <= dtsc_pkg::DEBOUNCE_LENGTH_RST;
            r_cfg.reload_hold_length <= dtsc_pkg::RELOAD_HOLD_LENGTH_RST;
            r_cfg.reload_shots       <= dtsc_pkg::RELOAD_SHOTS_RST;
            r_cfg.trigger_enabled    <= dtsc_pkg::TRIGGER_ENABLED_RST;
            r_cfg.ignore_gun_pin     <= dtsc_pkg::IGNORE_GUN_PIN_RST;
        end else if (i_wr) begin
            case (i_index)
                dtsc_pkg::CFG_DEBOUNCE_LENGTH:
                    r_cfg.debounce_length <= i_data[dtsc_pkg::DEB_W-1:0];
                dtsc_pkg::CFG_RELOAD_HOLD_LENGTH:
                    r_cfg.reload_hold_length <= i_data[dtsc_pkg::HOLD_W-1:0];
                dtsc_pkg::CFG_RELOAD_SHOTS:
                    r_cfg.reload_shots <= i_data[dtsc_pkg::SHOTS_W-1:0];
                dtsc_pkg::CFG_TRIGGER_ENABLED:
                    r_cfg.trigger_enabled <= i_data[0];
                dtsc_pkg::CFG_IGNORE_GUN_PIN:
                    r_cfg.ignore_gun_pin <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/dtsc_core.sv
// dtsc_core: trigger debounce machine, hold counter and shot count, one item per strobe.
// Depends on dtsc_pkg; the result is combinational and is registered by the caller.
`timescale 1ns / 1ps

module dtsc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  dtsc_pkg::t_cfg    i_cfg,
    input  dtsc_pkg::t_item   i_item,
    output dtsc_pkg::t_result o_result
);

    dtsc_pkg::t_phase             r_phase, n_phase;
    logic [dtsc_pkg::DEB_W-1:0]   r_deb, n_deb;
    logic [dtsc_pkg::HOLD_W-1:0]  r_hold, n_hold;
    logic [dtsc_pkg::SHOTS_W-1:0] r_shots, n_shots;

    logic       level;
    logic       fire;
    logic       start;
    logic [1:0] sound;
    logic [1:0] phase_code;

    assign level = (!i_cfg.ignore_gun_pin && i_item.gun_level) || i_item.button_level;

    always_comb begin
        n_phase = r_phase;
        n_deb   = r_deb;
        n_hold  = r_hold;
        n_shots = r_shots;
        fire    = 1'b0;
        start   = 1'b0;
        sound   = dtsc_pkg::SND_NONE;
        if (i_item.kind == dtsc_pkg::KIND_LOAD) begin
            n_shots = i_item.new_shot_count;
        end else begin
            // Phase transition on the trigger level
            case (r_phase)
                dtsc_pkg::PH_IDLE: begin
                    if (i_cfg.trigger_enabled && level) begin
                        n_phase = dtsc_pkg::PH_DEB_PRESS;
                        n_deb   = i_cfg.debounce_length;
                    end
                end
                dtsc_pkg::PH_DEB_PRESS: begin
                    if (!level) begin
                        n_phase = dtsc_pkg::PH_IDLE;
                    end else if (r_deb == '0) begin
                        n_hold  = '0;
                        n_phase = dtsc_pkg::PH_PRESSED;
                        if (r_shots != '0) begin
                            fire    = 1'b1;
                            sound   = dtsc_pkg::SND_FIRE;
                            n_shots = r_shots - dtsc_pkg::SHOTS_W'(1);
                        end else begin
                            sound = dtsc_pkg::SND_EMPTY;
                        end
                    end
                end
                dtsc_pkg::PH_PRESSED: begin
                    if (!level) begin
                        n_phase = dtsc_pkg::PH_DEB_RELEASE;
                        n_deb   = i_cfg.debounce_length;
                    end
                end
                default: begin
                    if (level) begin
                        n_phase = dtsc_pkg::PH_PRESSED;
                    end else if (r_deb == '0) begin
                        n_phase = dtsc_pkg::PH_IDLE;
                    end
                end
            endcase
            // Work of the phase just entered
            case (n_phase)
                dtsc_pkg::PH_IDLE: begin
                    start = !i_item.reload_timer_busy && (n_shots == '0);
                end
                dtsc_pkg::PH_PRESSED: begin
                    if (n_hold >= i_cfg.reload_hold_length) begin
                        sound   = dtsc_pkg::SND_RELOAD;
                        n_shots = i_cfg.reload_shots;
                    end
                    if (n_hold != dtsc_pkg::HOLD_MAX) begin
                        n_hold = n_hold + dtsc_pkg::HOLD_W'(1);
                    end
                end
                default: begin
                    if (n_deb != '0) begin
                        n_deb = n_deb - dtsc_pkg::DEB_W'(1);
                    end
                end
            endcase
        end
    end

    always_comb begin
        case (n_phase)
            dtsc_pkg::PH_IDLE:      phase_code = dtsc_pkg::PHC_IDLE;
            dtsc_pkg::PH_DEB_PRESS: phase_code = dtsc_pkg::PHC_DEB_PRESS;
            dtsc_pkg::PH_PRESSED:   phase_code = dtsc_pkg::PHC_PRESSED;
            default:                phase_code = dtsc_pkg::PHC_DEB_RELEASE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dtsc_pkg::PH_IDLE;
            r_deb   <= '0;
            r_hold  <= '0;
            r_shots <= dtsc_pkg::INITIAL_SHOTS_RST;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_deb   <= n_deb;
            r_hold  <= n_hold;
            r_shots <= n_shots;
        end
    end

    assign o_result.fire_pulse         = fire;
    assign o_result.sound_event        = sound;
    assign o_result.start_reload_timer = start;
    assign o_result.shots_remaining    = n_shots;
    assign o_result.phase_now          = phase_code;

endmodule

// File: rtl/core/debounced_trigger_shot_counter.sv
// debounced_trigger_shot_counter: top level of the trigger debounce and shot counter.
// Depends on dtsc_pkg, dtsc_if, dtsc_cfg_regs and dtsc_core.
//
//  channel  | dir | payload                                              | transaction
//  ---------+-----+------------------------------------------------------+-------------------
//  i_in     | in  | kind, gun_level, button_level, reload_timer_busy,   | one tick or load
//           |     | new_shot_count                                       |
//  o_out    | out | fire_pulse, sound_event, start_reload_timer,         | one result per item
//           |     | shots_remaining, phase_now                           |
//  i_cfg    | in  | index, data                                          | one register write
//
// The state update is a single pass of logic from the accepted item into the result
// register, so a new item is taken every cycle while the result is not stalled.
// Result valid rises in the cycle after the input transaction.
// Reset (synchronous, active low) restores register defaults, idles the machine and
// sets the shot count to its starting value. When the result is stalled, i_in holds
// off until the waiting result is taken; configuration writes are always accepted.
`timescale 1ns / 1ps

module debounced_trigger_shot_counter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtsc_in_if.sink    i_in,
    dtsc_out_if.source o_out,
    dtsc_cfg_if.sink   i_cfg
);

    dtsc_pkg::t_cfg    cfg;
    dtsc_pkg::t_item   item;
    dtsc_pkg::t_result result;
    dtsc_pkg::t_result r_result;
    logic              r_out_valid;
    logic              in_take;

    // Take a new item whenever the result register is empty or drains this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;

    // Configuration is never back-pressured
    assign i_cfg.ready = 1'b1;

    dtsc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    assign item.kind              = i_in.kind;
    assign item.gun_level         = i_in.gun_level;
    assign item.button_level      = i_in.button_level;
    assign item.reload_timer_busy = i_in.reload_timer_busy;
    assign item.new_shot_count    = i_in.new_shot_count;

    // Advance the machine only on an accepted item
    dtsc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_take),
        .i_cfg    (cfg),
        .i_item   (item),
        .o_result (result)
    );

    // Result register: hold while stalled, load on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_result <= result;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.fire_pulse         = r_result.fire_pulse;
    assign o_out.sound_event        = r_result.sound_event;
    assign o_out.start_reload_timer = r_result.start_reload_timer;
    assign o_out.shots_remaining    = r_result.shots_remaining;
    assign o_out.phase_now          = r_result.phase_now;

endmodule

// File: tb/testbench.sv
// Testbench for debounced_trigger_shot_counter: a queue-fed driver, a checking monitor and
// a cycle-accurate trigger/shot predictor. Depends on dtsc_pkg, dtsc_if and the RTL top.
`timescale 1ns / 1ps

module testbench;
    import dtsc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;
    // Register indexes past the last register; writes there must change nothing
    localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dtsc_in_if  in_if ();
    dtsc_out_if out_if ();
    dtsc_cfg_if cfg_if ();

    debounced_trigger_shot_counter dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always #10 i_clk = ~i_clk;

    // Items waiting to be offered, and the reports the trigger logic should produce
    t_item   pending_items[$];
    t_result trigger_reports[$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic stall_hold     = 1'b0;
    int   fault_count    = 0;
    int   cycle_count    = 0;

    // Mirror of the configuration registers
    logic [DEB_W-1:0]   cfg_debounce = DEBOUNCE_LENGTH_RST;
    logic [HOLD_W-1:0]  cfg_hold     = RELOAD_HOLD_LENGTH_RST;
    logic [SHOTS_W-1:0] cfg_reload   = RELOAD_SHOTS_RST;
    logic [SHOTS_W-1:0] cfg_start    = INITIAL_SHOTS_RST;
    logic               cfg_enable   = TRIGGER_ENABLED_RST;
    logic               cfg_ignore   = IGNORE_GUN_PIN_RST;

    // Mirror of the trigger state
    t_phase             trig_phase = PH_IDLE;
    logic [DEB_W-1:0]   deb_left   = '0;
    logic [HOLD_W-1:0]  hold_ticks = '0;
    logic [SHOTS_W-1:0] shot_count = INITIAL_SHOTS_RST;

    // Advance the trigger mirror by one item and return the report it yields.
    function automatic t_result step_trigger(input t_item it);
        t_result r;
        logic    lvl;
        r = '0;
        if (it.kind == KIND_LOAD) begin
            shot_count = it.new_shot_count;
        end else begin
            lvl = (!cfg_ignore && it.gun_level) || it.button_level;
            // First settle the phase transition
            case (trig_phase)
                PH_IDLE: begin
                    if (cfg_enable && lvl) begin
                        trig_phase = PH_DEB_PRESS;
                        deb_left   = cfg_debounce;
                    end
                end
                PH_DEB_PRESS: begin
                    if (!lvl) begin
                        trig_phase = PH_IDLE;
                    end else if (deb_left == '0) begin
                        hold_ticks = '0;
                        trig_phase = PH_PRESSED;
                        if (shot_count != '0) begin
                            r.fire_pulse  = 1'b1;
                            r.sound_event = SND_FIRE;
                            shot_count    = shot_count - 1'b1;
                        end else begin
                            r.sound_event = SND_EMPTY;
                        end
                    end
                end
                PH_PRESSED: begin
                    if (!lvl) begin
                        trig_phase = PH_DEB_RELEASE;
                        deb_left   = cfg_debounce;
                    end
                end
                default: begin
                    if (lvl)
                        trig_phase = PH_PRESSED;
                    else if (deb_left == '0)
                        trig_phase = PH_IDLE;
                end
            endcase
            // Then act on the phase that was reached
            case (trig_phase)
                PH_IDLE: begin
                    if (!it.reload_timer_busy && shot_count == '0)
                        r.start_reload_timer = 1'b1;
                end
                PH_PRESSED: begin
                    if (hold_ticks >= cfg_hold) begin
                        r.sound_event = SND_RELOAD;
                        shot_count    = cfg_reload;
                    end
                    if (hold_ticks != HOLD_MAX)
                        hold_ticks = hold_ticks + 1'b1;
                end
                default: begin
                    if (deb_left != '0)
                        deb_left = deb_left - 1'b1;
                end
            endcase
        end
        r.shots_remaining = shot_count;
        case (trig_phase)
            PH_IDLE:      r.phase_now = PHC_IDLE;
            PH_DEB_PRESS: r.phase_now = PHC_DEB_PRESS;
            PH_PRESSED:   r.phase_now = PHC_PRESSED;
            default:      r.phase_now = PHC_DEB_RELEASE;
        endcase
        return r;
    endfunction

    // Driver: offer the head of the pending queue, hold it until the transaction
    // completes, and predict each accepted item at the edge that takes it.
    always @(posedge i_clk) begin : drive_proc
        t_item nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                trigger_reports.push_back(step_trigger(pending_items.pop_front()));
            if (in_if.valid && !in_if.ready) begin
                // hold the offered item
            end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_items[0];
                in_if.valid             <= 1'b1;
                in_if.kind              <= nxt.kind;
                in_if.gun_level         <= nxt.gun_level;
                in_if.button_level      <= nxt.button_level;
                in_if.reload_timer_busy <= nxt.reload_timer_busy;
                in_if.new_shot_count    <= nxt.new_shot_count;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare every result transaction with the oldest expected report.
    always @(posedge i_clk) begin : check_proc
        t_result got;
        t_result want;
        logic    bad;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = {out_if.fire_pulse, out_if.sound_event, out_if.start_reload_timer,
                       out_if.shots_remaining, out_if.phase_now};
                if (trigger_reports.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display({"unexpected result: fire %0d sound %0d start %0d ",
                                  "shots %0d phase %0d"},
                                 got.fire_pulse, got.sound_event, got.start_reload_timer,
                                 got.shots_remaining, got.phase_now);
                end else begin
                    want = trigger_reports.pop_front();
                    bad  = (got.fire_pulse !== want.fire_pulse)
                        || (got.sound_event !== want.sound_event)
                        || (got.start_reload_timer !== want.start_reload_timer)
                        || (got.shots_remaining !== want.shots_remaining)
                        || (got.phase_now !== want.phase_now);
                    if (bad) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display({"mismatch: expected fire %0d sound %0d start %0d shots %0d ",
                                      "phase %0d, got fire %0d sound %0d start %0d shots %0d ",
                                      "phase %0d"},
                                     want.fire_pulse, want.sound_event, want.start_reload_timer,
                                     want.shots_remaining, want.phase_now,
                                     got.fire_pulse, got.sound_event, got.start_reload_timer,
                                     got.shots_remaining, got.phase_now);
                    end
                end
            end
            out_if.ready <= !stall_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off: block results so the output fills and input stalls.
    always begin : hold_off_proc
        wait (hold_req);
        @(posedge i_clk);
        stall_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        stall_hold <= 1'b0;
        hold_req = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Build a tick with the requested trigger level; pick the pins that form it at random.
    function automatic t_item tick_item(input logic lvl);
        t_item it;
        it                   = '0;
        it.kind              = KIND_TICK;
        it.reload_timer_busy = 1'($urandom_range(1));
        it.new_shot_count    = SHOTS_W'($urandom_range(255));
        if (lvl) begin
            case ($urandom_range(2))
                0: begin
                    it.gun_level    = 1'b1;
                    it.button_level = cfg_ignore;
                end
                1: begin
                    it.gun_level    = 1'($urandom_range(1));
                    it.button_level = 1'b1;
                end
                default: begin
                    it.gun_level    = 1'b1;
                    it.button_level = 1'b1;
                end
            endcase
        end else begin
            it.button_level = 1'b0;
            it.gun_level    = cfg_ignore ? 1'($urandom_range(1)) : 1'b0;
        end
        return it;
    endfunction

    task automatic push_tick(input logic gun, input logic btn, input logic busy);
        t_item it;
        it                   = '0;
        it.kind              = KIND_TICK;
        it.gun_level         = gun;
        it.button_level      = btn;
        it.reload_timer_busy = busy;
        it.new_shot_count    = SHOTS_W'($urandom_range(255));
        pending_items.push_back(it);
    endtask

    task automatic push_load(input logic [SHOTS_W-1:0] count);
        t_item it;
        it                   = '0;
        it.kind              = KIND_LOAD;
        it.gun_level         = 1'($urandom_range(1));
        it.button_level      = 1'($urandom_range(1));
        it.reload_timer_busy = 1'($urandom_range(1));
        it.new_shot_count    = count;
        pending_items.push_back(it);
    endtask

    // Queue a press of on_len ticks followed by a release of off_len ticks; a bouncy
    // contact flips single ticks now and then. Return the number of items queued.
    function automatic int queue_press(input int on_len, input int off_len, input logic bouncy);
        for (int i = 0; i < on_len; i++)
            pending_items.push_back(tick_item(!(bouncy && $urandom_range(7) == 0)));
        for (int i = 0; i < off_len; i++)
            pending_items.push_back(tick_item(bouncy && $urandom_range(7) == 0));
        return on_len + off_len;
    endfunction

    // Wait until every item is taken and every report is checked.
    task automatic drain();
        while (pending_items.size() != 0 || in_if.valid || trigger_reports.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // One register write transaction; mirror the register once it is taken.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_LENGTH:    cfg_debounce = val[DEB_W-1:0];
            CFG_RELOAD_HOLD_LENGTH: cfg_hold     = val[HOLD_W-1:0];
            CFG_RELOAD_SHOTS:       cfg_reload   = val[SHOTS_W-1:0];
            CFG_INITIAL_SHOTS:      cfg_start    = val[SHOTS_W-1:0];
            CFG_TRIGGER_ENABLED:    cfg_enable   = val[0];
            CFG_IGNORE_GUN_PIN:     cfg_ignore   = val[0];
            default: ;
        endcase
    endtask

    // Random phase: program all registers, then queue mostly well-formed presses,
    // some shot loads and some pin noise.
    task automatic run_phase(input logic [CDATA_W-1:0] deb, input logic [CDATA_W-1:0] hold,
                             input logic [CDATA_W-1:0] reload, input logic [CDATA_W-1:0] start,
                             input logic [CDATA_W-1:0] en, input logic [CDATA_W-1:0] ign,
                             input int send_pct, input int recv_pct, input int n_items,
                             input logic pressure);
        int queued;
        int on_cap;
        int off_cap;
        int pick;
        drain();
        write_reg(CFG_DEBOUNCE_LENGTH, deb);
        write_reg(CFG_RELOAD_HOLD_LENGTH, hold);
        write_reg(CFG_RELOAD_SHOTS, reload);
        write_reg(CFG_INITIAL_SHOTS, start);
        write_reg(CFG_TRIGGER_ENABLED, en);
        write_reg(CFG_IGNORE_GUN_PIN, ign);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (pressure)
            hold_req = 1'b1;
        // Keep presses short enough that long settings still fit the run
        on_cap  = int'(cfg_debounce) + int'(cfg_hold) + 4;
        on_cap  = (on_cap > 60) ? 60 : on_cap;
        off_cap = int'(cfg_debounce) + 4;
        off_cap = (off_cap > 60) ? 60 : off_cap;
        queued  = 0;
        while (queued < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                queued += queue_press($urandom_range(1, on_cap), $urandom_range(1, off_cap),
                                      $urandom_range(9) < 3);
            end else if (pick < 85) begin
                case ($urandom_range(3))
                    0:       push_load('0);
                    1:       push_load('1);
                    default: push_load(SHOTS_W'($urandom_range(255)));
                endcase
                queued++;
            end else begin
                for (int i = 0; i < 5; i++)
                    push_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                queued += 5;
            end
        end
        drain();
    endtask

    initial begin
        in_if.valid             = 1'b0;
        in_if.kind              = KIND_TICK;
        in_if.gun_level         = 1'b0;
        in_if.button_level      = 1'b0;
        in_if.reload_timer_busy = 1'b0;
        in_if.new_shot_count    = '0;
        out_if.ready            = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = CFG_DEBOUNCE_LENGTH;
        cfg_if.data             = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, timer request only when empty and timer free
        push_tick(1'b0, 1'b0, 1'b0);
        push_load('0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b1);
        push_load('1);
        push_tick(1'b1, 1'b0, 1'b0);     // start a long debounce from the gun pin
        push_tick(1'b0, 1'b0, 1'b0);     // drop it before it completes
        drain();

        // Zero debounce and zero hold: fire and reload land on the same tick
        write_reg(CFG_DEBOUNCE_LENGTH, '0);
        write_reg(CFG_RELOAD_HOLD_LENGTH, '0);
        write_reg(CFG_RELOAD_SHOTS, 20'd7);
        write_reg(CFG_INITIAL_SHOTS, '0);
        push_tick(1'b0, 1'b1, 1'b0);
        push_tick(1'b0, 1'b1, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        drain();

        // Empty click, then a hold long enough to reload to zero
        write_reg(CFG_DEBOUNCE_LENGTH, 20'd1);
        write_reg(CFG_RELOAD_HOLD_LENGTH, 20'd2);
        write_reg(CFG_RELOAD_SHOTS, '0);
        push_load('0);
        repeat (4) push_tick(1'b1, 1'b0, 1'b0);
        repeat (2) push_tick(1'b0, 1'b0, 1'b0);
        drain();

        // Ignored gun pin: gun alone does nothing, the button still presses
        write_reg(CFG_IGNORE_GUN_PIN, 20'd1);
        push_tick(1'b1, 1'b0, 1'b1);
        repeat (2) push_tick(1'b1, 1'b1, 1'b1);
        drain();

        // Disabled trigger mid-press: the press completes, no new press starts
        write_reg(CFG_TRIGGER_ENABLED, '0);
        push_tick(1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);
        repeat (2) push_tick(1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b0);
        drain();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);

        // Random phases across settings and idling modes
        run_phase(20'd1, 20'd1, 20'd0, 20'd0, 20'd1, 20'd0, 0, 0, 170, 1'b0);
        run_phase(20'd3, 20'd20, 20'd5, 20'd200, 20'd1, 20'd1, 64, 0, 170, 1'b0);
        run_phase(20'd0, 20'd0, 20'd255, 20'd1, 20'd1, 20'd0, 0, 64, 170, 1'b0);
        run_phase(20'd2, 20'd8, 20'd2, 20'd255, 20'd1, 20'd0, 9, 9, 170, 1'b1);
        run_phase(CDATA_W'($urandom_range(1, 6)), CDATA_W'($urandom_range(1, 30)),
                  CDATA_W'($urandom_range(255)), CDATA_W'($urandom_range(255)),
                  CDATA_W'($urandom_range(3) != 0), CDATA_W'($urandom_range(1)),
                  64, 64, 170, 1'b0);
        // All-ones data, gun-pin flag clear: widest settings, bits above each width set
        run_phase('1, '1, '1, '1, '1, 20'hFFFFE, 64, 64, 100, 1'b0);

        drain();
        repeat (10) @(posedge i_clk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/dtsc_pkg.sv
rtl/core/dtsc_if.sv
rtl/core/dtsc_cfg_regs.sv
rtl/core/dtsc_core.sv
rtl/core/debounced_trigger_shot_counter.sv
tb/testbench.sv
